// ===== src/ott_pkg.sv =====
// ----------------------------------------------------------------------------
// ott_pkg
// Shared types, codes and arithmetic helpers of the obstacle track table.
// ----------------------------------------------------------------------------
package ott_pkg;

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_POLAR = 3'd1;
    localparam logic [2:0] CMD_CART  = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [2:0] REG_EDGE_MARGIN    = 3'd0;
    localparam logic [2:0] REG_MAP_WIDTH      = 3'd1;
    localparam logic [2:0] REG_MAP_HEIGHT     = 3'd2;
    localparam logic [2:0] REG_RANGE_LIMIT    = 3'd3;
    localparam logic [2:0] REG_LEAST_DISTANCE = 3'd4;
    localparam logic [2:0] REG_BASE_RADIUS    = 3'd5;
    localparam logic [2:0] REG_FADE_RELOAD    = 3'd6;

    localparam int          MERGE_WINDOW = 100;
    localparam logic [15:0] RANGE_UNIT   = 16'd1000;
    localparam logic [11:0] RADIUS_MAX   = 12'd4095;
    // floor(p/1000) by multiply with ceil(2^24/1000), at most 1 high below saturation
    localparam logic [14:0] RECIP        = 15'd16778;
    localparam int          RECIP_SHIFT  = 24;
    localparam logic [25:0] SAT_PROD     = 26'd4094000;

    typedef struct packed {
        logic [9:0]  edge_margin;
        logic [12:0] map_width;
        logic [12:0] map_height;
        logic [15:0] range_limit;
        logic [11:0] least_distance;
        logic [9:0]  base_radius;
        logic [15:0] fade_reload;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic pad;
        logic trig;
        logic mult;
        logic sum;
        logic check;
        logic rad;
        logic scan_clear;
        logic scan_step;
        logic fetch;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       enabled;
        logic       slot_ok;
        logic       reject;
        logic       scan_stop;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [14:0] sine_tab(input logic [4:0] k);
        logic [14:0] v;
        case (k)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] quarter_sine(input logic [12:0] u);
        logic [4:0]         i;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [24:0] p;
        logic signed [15:0] s;
        i = u[12:8];
        a = $signed({1'b0, sine_tab(i)});
        b = $signed({1'b0, sine_tab(5'(i + 5'd1))});
        p = 25'(b - a) * $signed({1'b0, u[7:0]}) + 25'sd128;
        s = a + 16'(p >>> 8);
        if (i >= 5'd16) begin
            s = 16'sd16384;
        end
        return s[14:0];
    endfunction

    function automatic logic signed [15:0] sine_of(input logic [13:0] p);
        logic [12:0] u;
        logic [15:0] v;
        u = p[12] ? (13'd4096 - {1'b0, p[11:0]}) : {1'b0, p[11:0]};
        v = {1'b0, quarter_sine(u)};
        return p[13] ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic off_map(input logic signed [20:0] x,
                                     input logic signed [20:0] y,
                                     input cfg_t c);
        logic signed [21:0] xs;
        logic signed [21:0] ys;
        logic signed [21:0] ms;
        logic signed [21:0] wl;
        logic signed [21:0] hl;
        xs = 22'(x);
        ys = 22'(y);
        ms = $signed({12'd0, c.edge_margin});
        wl = $signed({9'd0, c.map_width}) - ms;
        hl = $signed({9'd0, c.map_height}) - ms;
        return (xs < ms) || (xs > wl) || (ys < ms) || (ys > hl);
    endfunction

endpackage

// ===== src/ott_cfg.sv =====
// ----------------------------------------------------------------------------
// ott_cfg
// Register bank behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module ott_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ott_pkg::cfg_t cfg
);
    import ott_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_EDGE_MARGIN:    cfg_next.edge_margin    = pwdata[9:0];
                REG_MAP_WIDTH:      cfg_next.map_width      = pwdata[12:0];
                REG_MAP_HEIGHT:     cfg_next.map_height     = pwdata[12:0];
                REG_RANGE_LIMIT:    cfg_next.range_limit    = pwdata[15:0];
                REG_LEAST_DISTANCE: cfg_next.least_distance = pwdata[11:0];
                REG_BASE_RADIUS:    cfg_next.base_radius    = pwdata[9:0];
                REG_FADE_RELOAD:    cfg_next.fade_reload    = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_EDGE_MARGIN:    prdata = {22'd0, cfg_reg.edge_margin};
            REG_MAP_WIDTH:      prdata = {19'd0, cfg_reg.map_width};
            REG_MAP_HEIGHT:     prdata = {19'd0, cfg_reg.map_height};
            REG_RANGE_LIMIT:    prdata = {16'd0, cfg_reg.range_limit};
            REG_LEAST_DISTANCE: prdata = {20'd0, cfg_reg.least_distance};
            REG_BASE_RADIUS:    prdata = {22'd0, cfg_reg.base_radius};
            REG_FADE_RELOAD:    prdata = {16'd0, cfg_reg.fade_reload};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_margin    <= 10'd100;
            cfg_reg.map_width      <= 13'd3000;
            cfg_reg.map_height     <= 13'd2000;
            cfg_reg.range_limit    <= 16'd4000;
            cfg_reg.least_distance <= 12'd500;
            cfg_reg.base_radius    <= 10'd200;
            cfg_reg.fade_reload    <= 16'd600;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/ott_ctrl.sv =====
// ----------------------------------------------------------------------------
// ott_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module ott_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ott_pkg::dp_stat_t stat,
    output ott_pkg::dp_cmd_t  cmd
);
    import ott_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_DECODE = 11'b00000000010,
        ST_DIST   = 11'b00000000100,
        ST_TRIG   = 11'b00000001000,
        ST_MULT   = 11'b00000010000,
        ST_SUM    = 11'b00000100000,
        ST_CHECK  = 11'b00001000000,
        ST_RAD    = 11'b00010000000,
        ST_SCAN   = 11'b00100000000,
        ST_FETCH  = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                case (stat.op)
                    CMD_POLAR: begin
                        if (stat.enabled) state_next = ST_DIST;
                    end
                    CMD_CART: begin
                        if (stat.enabled && stat.slot_ok) state_next = ST_FETCH;
                    end
                    CMD_READ: begin
                        if (stat.slot_ok) state_next = ST_FETCH;
                    end
                    CMD_TICK: begin
                        if (stat.enabled) begin
                            cmd.scan_clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DIST: begin
                cmd.pad    = 1'b1;
                state_next = ST_TRIG;
            end
            ST_TRIG: begin
                cmd.trig   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_RAD;
            end
            ST_RAD: begin
                cmd.rad        = 1'b1;
                cmd.scan_clear = !stat.reject;
                state_next     = stat.reject ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_stop) state_next = ST_DONE;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold here while the previous result still sits unread
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/ott_dp.sv =====
// ----------------------------------------------------------------------------
// ott_dp
// Datapath: hit geometry, slot memories, slot walk and result register.
// ----------------------------------------------------------------------------
module ott_dp #(
    parameter int SLOT_COUNT = 8,
    parameter int ANGLE_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ott_pkg::cfg_t       cfg,
    input  ott_pkg::dp_cmd_t    cmd,
    output ott_pkg::dp_stat_t   stat,
    input  logic [2:0]          s_cmd,
    input  logic signed [15:0]  s_robot_x,
    input  logic signed [15:0]  s_robot_y,
    input  logic [11:0]         s_bearing,
    input  logic [15:0]         s_range_mm,
    input  logic signed [15:0]  s_point_x,
    input  logic signed [15:0]  s_point_y,
    input  logic [2:0]          s_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_slot_used,
    output logic signed [15:0]  m_circle_x,
    output logic signed [15:0]  m_circle_y,
    output logic [11:0]         m_circle_r,
    output logic                m_merged,
    output logic [15:0]         m_fade_left
);
    import ott_pkg::*;

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int ENTRY_W = 44;

    // request fields
    logic [2:0]         op_reg;
    logic signed [15:0] robot_x_reg;
    logic signed [15:0] robot_y_reg;
    logic [11:0]        bearing_reg;
    logic [15:0]        range_reg;
    logic signed [15:0] point_x_reg;
    logic signed [15:0] point_y_reg;
    logic [2:0]         slot_reg;

    // hit geometry
    logic [15:0]        d_reg;
    logic               drej_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic signed [32:0] prod_x_reg;
    logic signed [32:0] prod_y_reg;
    logic signed [20:0] x_reg;
    logic signed [20:0] y_reg;
    logic [25:0]        radp_reg;
    logic [16:0]        q0_reg;
    logic               reject_reg;
    logic [11:0]        radius_reg;

    // table state
    logic                  enabled_reg;
    logic                  enabled_next;
    logic [IDX_W-1:0]      cursor_reg;
    logic [IDX_W-1:0]      cursor_next;
    logic [SLOT_COUNT-1:0] cvalid_reg;
    logic [SLOT_COUNT-1:0] cvalid_next;
    logic [SLOT_COUNT-1:0] fvalid_reg;
    logic [SLOT_COUNT-1:0] fvalid_next;
    logic [ENTRY_W-1:0]    circ_mem [SLOT_COUNT];
    logic [15:0]           fade_mem [SLOT_COUNT];
    logic [ENTRY_W-1:0]    rd_circ_reg;
    logic [15:0]           rd_fade_reg;
    logic                  rd_cv_reg;
    logic                  rd_fv_reg;

    // walk
    logic [CNT_W-1:0] cnt_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [IDX_W-1:0] hit_slot_reg;
    logic [IDX_W-1:0] hit_slot_next;
    logic [15:0]      hit_fade_reg;
    logic [15:0]      hit_fade_next;

    // result register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [2:0]         slot_used_reg;
    logic signed [15:0] circle_x_reg;
    logic signed [15:0] circle_y_reg;
    logic [11:0]        circle_r_reg;
    logic               merged_reg;
    logic [15:0]        fade_left_reg;
    logic [2:0]         res_slot;
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic [11:0]        res_r;
    logic               res_merged;
    logic [15:0]        res_fade;

    // comb helpers
    logic [13:0]        phase;
    logic [16:0]        d17;
    logic [15:0]        scale;
    logic [26:0]        q0_prod;
    logic [16:0]        q_fix;
    logic [IDX_W-1:0]   slot_idx;
    logic               slot_ok;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               cw_en;
    logic [IDX_W-1:0]   cw_addr;
    logic [ENTRY_W-1:0] cw_data;
    logic               fw_en;
    logic [IDX_W-1:0]   fw_addr;
    logic [15:0]        fw_data;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [11:0]        rr;
    logic [15:0]        rfade;
    logic signed [21:0] dx;
    logic signed [21:0] dy;
    logic               eval_ok;
    logic               match;
    logic               last;
    logic [IDX_W-1:0]   eidx;
    logic               cart_empty;
    logic [IDX_W-1:0]   tgt;

    assign slot_idx = IDX_W'(slot_reg);
    assign slot_ok  = (32'(slot_reg) < SLOT_COUNT);
    assign phase    = 14'((({2'b00, bearing_reg}) & 14'((1 << ANGLE_BITS) - 1))
                      << (14 - ANGLE_BITS));
    assign d17      = {1'b0, range_reg} + {7'd0, cfg.edge_margin};
    assign scale    = (d_reg < RANGE_UNIT) ? RANGE_UNIT : d_reg;
    assign q0_prod  = 27'(q0_reg) * 27'(RANGE_UNIT);
    assign q_fix    = (q0_prod > {1'b0, radp_reg}) ? (q0_reg - 17'd1) : q0_reg;

    assign rx    = rd_cv_reg ? $signed(rd_circ_reg[43:28]) : 16'sd0;
    assign ry    = rd_cv_reg ? $signed(rd_circ_reg[27:12]) : 16'sd0;
    assign rr    = rd_cv_reg ? rd_circ_reg[11:0] : 12'd0;
    assign rfade = rd_fv_reg ? rd_fade_reg : 16'd0;

    assign dx   = 22'(rx) - 22'(x_reg);
    assign dy   = 22'(ry) - 22'(y_reg);
    assign eidx = IDX_W'(cnt_reg - CNT_W'(1));
    assign last = (cnt_reg == CNT_W'(SLOT_COUNT));

    assign eval_ok = cmd.scan_step && (cnt_reg != '0);
    assign match   = eval_ok && (op_reg == CMD_POLAR) && (rr != 12'd0)
                     && (dx < 22'(MERGE_WINDOW)) && (dx > -22'(MERGE_WINDOW))
                     && (dy < 22'(MERGE_WINDOW)) && (dy > -22'(MERGE_WINDOW));

    assign rd_en   = cmd.fetch || (cmd.scan_step && !last);
    assign rd_addr = cmd.fetch ? slot_idx : cnt_reg[IDX_W-1:0];

    assign cart_empty = ((point_x_reg == 16'sd0) && (point_y_reg == 16'sd0))
                        || off_map(21'(point_x_reg), 21'(point_y_reg), cfg);
    assign tgt = hit_reg ? hit_slot_reg : cursor_reg;

    assign stat.op        = op_reg;
    assign stat.enabled   = enabled_reg;
    assign stat.slot_ok   = slot_ok;
    assign stat.reject    = reject_reg;
    assign stat.scan_stop = cmd.scan_step && (match || last);
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        enabled_next  = enabled_reg;
        cursor_next   = cursor_reg;
        cvalid_next   = cvalid_reg;
        fvalid_next   = fvalid_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        hit_fade_next = hit_fade_reg;
        cw_en         = 1'b0;
        cw_addr       = tgt;
        cw_data       = {x_reg[15:0], y_reg[15:0], radius_reg};
        fw_en         = 1'b0;
        fw_addr       = eidx;
        fw_data       = rfade - 16'd1;
        res_slot      = 3'd0;
        res_x         = 16'sd0;
        res_y         = 16'sd0;
        res_r         = 12'd0;
        res_merged    = 1'b0;
        res_fade      = 16'd0;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cmd.scan_clear) begin
            hit_next = 1'b0;
        end
        if (match) begin
            hit_next      = 1'b1;
            hit_slot_next = eidx;
            hit_fade_next = rfade;
        end
        // tick: age a live slot, or drop it once its fade has run out
        if (eval_ok && (op_reg == CMD_TICK) && (rr != 12'd0)) begin
            if (rfade != 16'd0) begin
                fw_en = 1'b1;
            end else begin
                cvalid_next[eidx] = 1'b0;
            end
        end

        if (cmd.finish) begin
            m_valid_next = 1'b1;
            case (op_reg)
                CMD_INIT: begin
                    enabled_next = 1'b1;
                    cvalid_next  = '0;
                end
                CMD_POLAR: begin
                    if (enabled_reg && !reject_reg) begin
                        cw_en      = 1'b1;
                        res_slot   = 3'(tgt);
                        res_x      = x_reg[15:0];
                        res_y      = y_reg[15:0];
                        res_r      = radius_reg;
                        res_merged = hit_reg;
                        res_fade   = hit_reg ? hit_fade_reg : cfg.fade_reload;
                        if (!hit_reg) begin
                            fw_en   = 1'b1;
                            fw_addr = cursor_reg;
                            fw_data = cfg.fade_reload;
                            cursor_next = (32'(cursor_reg) >= SLOT_COUNT - 1)
                                          ? '0 : IDX_W'(cursor_reg + IDX_W'(1));
                        end
                    end
                end
                CMD_CART: begin
                    if (enabled_reg && slot_ok) begin
                        cw_en    = 1'b1;
                        cw_addr  = slot_idx;
                        res_slot = slot_reg;
                        res_fade = rfade;
                        if (!cart_empty) begin
                            res_x = point_x_reg;
                            res_y = point_y_reg;
                            res_r = {2'b00, cfg.base_radius};
                        end
                        cw_data = {res_x, res_y, res_r};
                    end
                end
                CMD_READ: begin
                    if (slot_ok) begin
                        res_slot = slot_reg;
                        res_x    = rx;
                        res_y    = ry;
                        res_r    = rr;
                        res_fade = rfade;
                    end
                end
                default: m_valid_next = 1'b1;
            endcase
        end

        if (cw_en) cvalid_next[cw_addr] = 1'b1;
        if (fw_en) fvalid_next[fw_addr] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cw_en) circ_mem[cw_addr] <= cw_data;
        if (fw_en) fade_mem[fw_addr] <= fw_data;
        if (rd_en) begin
            rd_circ_reg <= circ_mem[rd_addr];
            rd_fade_reg <= fade_mem[rd_addr];
            rd_cv_reg   <= cvalid_reg[rd_addr];
            rd_fv_reg   <= fvalid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_cmd;
            robot_x_reg <= s_robot_x;
            robot_y_reg <= s_robot_y;
            bearing_reg <= s_bearing;
            range_reg   <= s_range_mm;
            point_x_reg <= s_point_x;
            point_y_reg <= s_point_y;
            slot_reg    <= s_slot;
        end
        if (cmd.pad) begin
            drej_reg <= (d17 >= {1'b0, cfg.range_limit});
            d_reg    <= (d17 < {5'd0, cfg.least_distance}) ? {4'd0, cfg.least_distance}
                                                           : d17[15:0];
        end
        if (cmd.trig) begin
            sin_reg <= sine_of(phase);
            cos_reg <= sine_of(14'(phase + 14'd4096));
        end
        if (cmd.mult) begin
            prod_x_reg <= $signed({1'b0, d_reg}) * cos_reg;
            prod_y_reg <= $signed({1'b0, d_reg}) * sin_reg;
        end
        if (cmd.sum) begin
            // round to nearest, ties toward plus infinity
            x_reg    <= 21'(robot_x_reg) + 21'((prod_x_reg + 33'sd8192) >>> 14);
            y_reg    <= 21'(robot_y_reg) + 21'((prod_y_reg + 33'sd8192) >>> 14);
            radp_reg <= 26'(cfg.base_radius) * 26'(scale);
        end
        if (cmd.check) begin
            reject_reg <= drej_reg || off_map(x_reg, y_reg, cfg);
            q0_reg     <= 17'((41'(radp_reg) * 41'(RECIP)) >> RECIP_SHIFT);
        end
        if (cmd.rad) begin
            radius_reg <= (radp_reg >= SAT_PROD) ? RADIUS_MAX : 12'(q_fix + 17'd1);
        end
        if (cmd.scan_clear) begin
            cnt_reg <= '0;
        end else if (cmd.scan_step) begin
            cnt_reg <= CNT_W'(cnt_reg + CNT_W'(1));
        end
        hit_slot_reg <= hit_slot_next;
        hit_fade_reg <= hit_fade_next;
        if (cmd.finish) begin
            slot_used_reg <= res_slot;
            circle_x_reg  <= res_x;
            circle_y_reg  <= res_y;
            circle_r_reg  <= res_r;
            merged_reg    <= res_merged;
            fade_left_reg <= res_fade;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            cursor_reg  <= '0;
            cvalid_reg  <= '0;
            fvalid_reg  <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            enabled_reg <= enabled_next;
            cursor_reg  <= cursor_next;
            cvalid_reg  <= cvalid_next;
            fvalid_reg  <= fvalid_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_slot_used = slot_used_reg;
    assign m_circle_x  = circle_x_reg;
    assign m_circle_y  = circle_y_reg;
    assign m_circle_r  = circle_r_reg;
    assign m_merged    = merged_reg;
    assign m_fade_left = fade_left_reg;

endmodule

// ===== src/obstacle_track_table.sv =====
// ----------------------------------------------------------------------------
// obstacle_track_table
// Table of circular obstacles with fade counters, fed by lidar hits.
// ----------------------------------------------------------------------------
//  channel  | prefix | handshake             | content
//  request  | s_     | s_valid / s_ready     | command, robot pose, hit, point, slot
//  result   | m_     | m_valid / m_ready     | slot, circle, merged flag, fade
//  config   | p      | psel+penable, pready  | seven registers at 4*index
//
//  one request at a time: polar add runs decode, six geometry steps and, unless
//  rejected, a walk over the slot memory ending early on a merge; tick runs decode
//  and the walk, read and cartesian add decode and a slot fetch, init decode alone.
//  reset is synchronous active low; no clearing pass, slot contents clear at once.
//  a finished result waits in the output register; the next request is taken
//  meanwhile and only stalls at its own result if that register is still full.
module obstacle_track_table #(
    parameter int SLOT_COUNT = 8,
    parameter int ANGLE_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [15:0] s_robot_x,
    input  logic signed [15:0] s_robot_y,
    input  logic [11:0]        s_bearing,
    input  logic [15:0]        s_range_mm,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic [2:0]         s_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_slot_used,
    output logic signed [15:0] m_circle_x,
    output logic signed [15:0] m_circle_y,
    output logic [11:0]        m_circle_r,
    output logic               m_merged,
    output logic [15:0]        m_fade_left,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ott_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ott_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ott_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ott_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .s_cmd       (s_cmd),
        .s_robot_x   (s_robot_x),
        .s_robot_y   (s_robot_y),
        .s_bearing   (s_bearing),
        .s_range_mm  (s_range_mm),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slot_used (m_slot_used),
        .m_circle_x  (m_circle_x),
        .m_circle_y  (m_circle_y),
        .m_circle_r  (m_circle_r),
        .m_merged    (m_merged),
        .m_fade_left (m_fade_left)
    );

endmodule

// ===== src/ott_chk.sv =====
// ----------------------------------------------------------------------------
// ott_chk
// Port-level checks of the obstacle track table, bound to the top level.
// ----------------------------------------------------------------------------
module ott_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_circle_x,
    input logic [11:0]        m_circle_r,
    input logic               m_merged,
    input logic               pready
);

    // a held result stays valid and keeps its circle x and radius
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_circle_x) && $stable(m_circle_r))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken back to back");

    a_merge_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_merged |-> m_circle_r != 12'd0)
        else $error("merged result with empty radius");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("config port not ready");

endmodule

bind obstacle_track_table ott_chk u_ott_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_circle_x (m_circle_x),
    .m_circle_r (m_circle_r),
    .m_merged   (m_merged),
    .pready     (pready)
);
